[hw/rtl/pidf_pkg.sv]
// Shared types, constants and saturating arithmetic for the filtered-derivative PID block.
`default_nettype none

package pidf_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int FRAC_BITS       = 16;
  localparam int LIMIT_WIDTH     = DATA_WIDTH - 1;
  localparam int REG_INDEX_WIDTH = 3;

  typedef logic signed [DATA_WIDTH-1:0] fix_t;
  typedef logic [LIMIT_WIDTH-1:0] lim_t;

  localparam fix_t FIX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_FILTER_COEF = 3'd3,
    REG_DRIVE_LIMIT = 3'd4,
    REG_INTEG_LIMIT = 3'd5
  } reg_index_t;

  typedef struct packed {
    fix_t gain_prop;
    fix_t gain_integ;
    fix_t gain_deriv;
    fix_t filter_coef;
    lim_t drive_limit;
    lim_t integ_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_PROP,
    ST_C_INTEG,
    ST_C_FILT,
    ST_T_KE,
    ST_T_KEDT,
    ST_T_SUM,
    ST_T_UPD,
    ST_F_ACC,
    ST_F_DIFF,
    ST_F_MUL,
    ST_F_DERIV,
    ST_F_OUT
  } state_t;

  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? FIX_MIN : FIX_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic fix_t sat_sub(fix_t a, fix_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? FIX_MIN : FIX_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic fix_t lim_to_fix(lim_t l);
    return $signed({1'b0, l});
  endfunction

  // Clamp to the symmetric range [-l, l].
  function automatic fix_t clamp_sym(fix_t v, lim_t l);
    fix_t hi;
    fix_t lo;
    hi = lim_to_fix(l);
    lo = -hi;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pidf_regs.sv]
// Configuration register file with a plain write port.
`default_nettype none

module pidf_regs (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_we,
  input  wire logic [pidf_pkg::REG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [pidf_pkg::DATA_WIDTH-1:0]         cfg_data,
  output pidf_pkg::cfg_t                               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop   <= '0;
      cfg.gain_integ  <= '0;
      cfg.gain_deriv  <= '0;
      cfg.filter_coef <= '0;
      cfg.drive_limit <= '1;
      cfg.integ_limit <= '0;
    end else if (cfg_we) begin
      unique case (pidf_pkg::reg_index_t'(cfg_index))
        pidf_pkg::REG_GAIN_PROP:   cfg.gain_prop   <= cfg_data;
        pidf_pkg::REG_GAIN_INTEG:  cfg.gain_integ  <= cfg_data;
        pidf_pkg::REG_GAIN_DERIV:  cfg.gain_deriv  <= cfg_data;
        pidf_pkg::REG_FILTER_COEF: cfg.filter_coef <= cfg_data;
        pidf_pkg::REG_DRIVE_LIMIT: cfg.drive_limit <= cfg_data[pidf_pkg::LIMIT_WIDTH-1:0];
        pidf_pkg::REG_INTEG_LIMIT: cfg.integ_limit <= cfg_data[pidf_pkg::LIMIT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pidf_mul.sv]
// Shared fixed-point multiplier: exact product, floor shift, saturation, registered result.
`default_nettype none

module pidf_mul (
  input  wire logic           clk,
  input  wire pidf_pkg::fix_t a,
  input  wire pidf_pkg::fix_t b,
  output pidf_pkg::fix_t      q
);

  localparam int PROD_WIDTH  = 2 * pidf_pkg::DATA_WIDTH;
  localparam int SHIFT_WIDTH = PROD_WIDTH - pidf_pkg::FRAC_BITS;
  localparam int HEAD_WIDTH  = SHIFT_WIDTH - pidf_pkg::DATA_WIDTH + 1;

  logic signed [PROD_WIDTH-1:0]  prod;
  logic signed [SHIFT_WIDTH-1:0] shifted;
  logic [HEAD_WIDTH-1:0]         head;
  pidf_pkg::fix_t                q_next;

  assign prod = a * b;
  // Dropping the fraction bits of a two's-complement product rounds toward minus infinity.
  assign shifted = prod[PROD_WIDTH-1:pidf_pkg::FRAC_BITS];
  assign head    = shifted[SHIFT_WIDTH-1:pidf_pkg::DATA_WIDTH-1];

  always_comb begin
    if (head == '0 || head == '1) begin
      q_next = shifted[pidf_pkg::DATA_WIDTH-1:0];
    end else if (shifted[SHIFT_WIDTH-1]) begin
      q_next = pidf_pkg::FIX_MIN;
    end else begin
      q_next = pidf_pkg::FIX_MAX;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

[hw/rtl/pid_filtered_derivative_antiwindup.sv]
// Top level: sequencer, controller state and output register around one shared multiplier.
`default_nettype none

// PID controller with a first-order filtered derivative and anti-windup, in signed Q16.16.
// All multiplications go through one registered multiplier under a small sequencer, so the
// block takes one item at a time and holds the input side busy from acceptance until its
// sequence ends, with integ_limit zero (output clamping mode) or non-zero (term clamping
// mode). The result is registered at the end of the sequence and may wait on drive_stall
// while a new item is accepted; the sequencer then holds in its last step until the
// pending result is taken. Configuration must be written while the block is idle.
module pid_filtered_derivative_antiwindup (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [pidf_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [pidf_pkg::DATA_WIDTH-1:0]       cfg_data,
  input  wire logic                                  err_valid,
  output logic                                       err_stall,
  input  wire logic signed [pidf_pkg::DATA_WIDTH-1:0] error_in,
  input  wire logic [pidf_pkg::LIMIT_WIDTH-1:0]      time_step,
  input  wire logic                                  sat_flag,
  output logic                                       drive_valid,
  input  wire logic                                  drive_stall,
  output logic signed [pidf_pkg::DATA_WIDTH-1:0]     drive_out
);

  localparam int MSB = pidf_pkg::DATA_WIDTH - 1;

  pidf_pkg::cfg_t   cfg;
  pidf_pkg::state_t state, state_next;

  pidf_pkg::fix_t err_r;
  pidf_pkg::lim_t dt_r;
  logic           sat_r;

  pidf_pkg::fix_t prop_term, prop_term_next;
  pidf_pkg::fix_t integ_term, integ_term_next;
  pidf_pkg::fix_t filter_acc, filter_acc_next;
  pidf_pkg::fix_t deriv_term, deriv_term_next;
  pidf_pkg::fix_t integ_rate, integ_rate_next;
  pidf_pkg::fix_t tmp_a, tmp_a_next;
  pidf_pkg::fix_t tmp_b, tmp_b_next;
  pidf_pkg::fix_t drive_out_next;
  logic           drive_valid_next;

  pidf_pkg::fix_t mul_a, mul_b, mul_q;
  pidf_pkg::fix_t dt_fix, ul_fix, u_sum, t_sum;
  logic           in_accept, clamp_mode, ske_pos, ske_neg, pi_agree, t_oppose, out_free;

  pidf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  assign err_stall  = (state != pidf_pkg::ST_IDLE);
  assign in_accept  = err_valid && !err_stall;
  assign clamp_mode = (cfg.integ_limit == '0);
  assign out_free   = !drive_valid || !drive_stall;

  assign dt_fix = pidf_pkg::lim_to_fix(dt_r);
  assign ul_fix = pidf_pkg::lim_to_fix(cfg.drive_limit);
  assign u_sum  = pidf_pkg::sat_add(tmp_b, deriv_term);
  assign t_sum  = pidf_pkg::sat_add(tmp_b, tmp_a);

  // Sign of Ki times sign of e, taken from the factors themselves.
  assign ske_pos = (cfg.gain_integ != '0) && (err_r != '0) && (cfg.gain_integ[MSB] == err_r[MSB]);
  assign ske_neg = (cfg.gain_integ != '0) && (err_r != '0) && (cfg.gain_integ[MSB] != err_r[MSB]);
  assign pi_agree = ((tmp_b > 0) && ske_pos) || ((tmp_b < 0) && ske_neg);
  assign t_oppose = ((t_sum > 0) && ske_neg) || ((t_sum < 0) && ske_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pidf_pkg::ST_IDLE;
      prop_term   <= '0;
      integ_term  <= '0;
      filter_acc  <= '0;
      deriv_term  <= '0;
      integ_rate  <= '0;
      drive_valid <= 1'b0;
    end else begin
      state       <= state_next;
      prop_term   <= prop_term_next;
      integ_term  <= integ_term_next;
      filter_acc  <= filter_acc_next;
      deriv_term  <= deriv_term_next;
      integ_rate  <= integ_rate_next;
      drive_valid <= drive_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      err_r <= error_in;
      dt_r  <= time_step;
      sat_r <= sat_flag;
    end
    tmp_a     <= tmp_a_next;
    tmp_b     <= tmp_b_next;
    drive_out <= drive_out_next;
  end

  always_comb begin
    state_next       = state;
    mul_a            = '0;
    mul_b            = '0;
    prop_term_next   = prop_term;
    integ_term_next  = integ_term;
    filter_acc_next  = filter_acc;
    deriv_term_next  = deriv_term;
    integ_rate_next  = integ_rate;
    tmp_a_next       = tmp_a;
    tmp_b_next       = tmp_b;
    drive_out_next   = drive_out;
    drive_valid_next = drive_valid && drive_stall;

    unique case (state)
      pidf_pkg::ST_IDLE: begin
        if (err_valid) begin
          state_next = clamp_mode ? pidf_pkg::ST_C_PROP : pidf_pkg::ST_T_KE;
        end
      end
      pidf_pkg::ST_C_PROP: begin
        mul_a      = cfg.gain_prop;
        mul_b      = err_r;
        state_next = pidf_pkg::ST_C_INTEG;
      end
      pidf_pkg::ST_C_INTEG: begin
        prop_term_next = mul_q;
        mul_a          = integ_rate;
        mul_b          = dt_fix;
        state_next     = pidf_pkg::ST_C_FILT;
      end
      pidf_pkg::ST_C_FILT: begin
        integ_term_next = pidf_pkg::sat_add(integ_term, mul_q);
        mul_a           = deriv_term;
        mul_b           = dt_fix;
        state_next      = pidf_pkg::ST_F_ACC;
      end
      pidf_pkg::ST_T_KE: begin
        mul_a      = cfg.gain_integ;
        mul_b      = err_r;
        state_next = pidf_pkg::ST_T_KEDT;
      end
      pidf_pkg::ST_T_KEDT: begin
        mul_a      = mul_q;
        mul_b      = dt_fix;
        state_next = pidf_pkg::ST_T_SUM;
      end
      pidf_pkg::ST_T_SUM: begin
        tmp_a_next = mul_q;
        tmp_b_next = pidf_pkg::sat_add(prop_term, integ_term);
        mul_a      = cfg.gain_prop;
        mul_b      = err_r;
        state_next = pidf_pkg::ST_T_UPD;
      end
      pidf_pkg::ST_T_UPD: begin
        // Terms move unless the actuator is saturated and the step would push further.
        if (t_oppose || !sat_r) begin
          prop_term_next  = pidf_pkg::clamp_sym(mul_q, cfg.drive_limit);
          integ_term_next = pidf_pkg::clamp_sym(pidf_pkg::sat_add(integ_term, tmp_a),
                                                cfg.integ_limit);
        end
        mul_a      = deriv_term;
        mul_b      = dt_fix;
        state_next = pidf_pkg::ST_F_ACC;
      end
      pidf_pkg::ST_F_ACC: begin
        filter_acc_next = pidf_pkg::sat_add(filter_acc, mul_q);
        mul_a           = cfg.gain_deriv;
        mul_b           = err_r;
        state_next      = pidf_pkg::ST_F_DIFF;
      end
      pidf_pkg::ST_F_DIFF: begin
        tmp_a_next = pidf_pkg::sat_sub(mul_q, filter_acc);
        state_next = pidf_pkg::ST_F_MUL;
      end
      pidf_pkg::ST_F_MUL: begin
        mul_a      = cfg.filter_coef;
        mul_b      = tmp_a;
        state_next = pidf_pkg::ST_F_DERIV;
      end
      pidf_pkg::ST_F_DERIV: begin
        deriv_term_next = mul_q;
        tmp_b_next      = pidf_pkg::sat_add(prop_term, integ_term);
        mul_a           = cfg.gain_integ;
        mul_b           = err_r;
        state_next      = pidf_pkg::ST_F_OUT;
      end
      pidf_pkg::ST_F_OUT: begin
        // Keep Ki*e on the multiplier output while a pending result blocks this step.
        mul_a = cfg.gain_integ;
        mul_b = err_r;
        if (out_free) begin
          if (clamp_mode) begin
            if (pi_agree && ((u_sum > ul_fix) || (u_sum < -ul_fix) || sat_r)) begin
              integ_rate_next = '0;
            end else begin
              integ_rate_next = mul_q;
            end
            drive_out_next = pidf_pkg::clamp_sym(u_sum, cfg.drive_limit);
          end else begin
            drive_out_next = u_sum;
          end
          drive_valid_next = 1'b1;
          state_next       = pidf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pidf_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> err_stall)
    else $error("input side not held busy after an item was accepted");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (rst)
    (drive_valid && !$past(drive_valid)) |-> $past(state == pidf_pkg::ST_F_OUT))
    else $error("result appeared outside the output step");

  a_output_clamped: assert property (@(posedge clk) disable iff (rst)
    (drive_valid && !$past(drive_valid) && $past(clamp_mode))
      |-> ((drive_out <= $past(ul_fix)) && (drive_out >= -$past(ul_fix))))
    else $error("drive value exceeds the drive limit in clamping mode");
`endif

endmodule

`default_nettype wire
